// ----- rtl/core/crlfx_pkg.sv -----
// Shared constants and types for the CR LF line extractor.
package crlfx_pkg;

    localparam int STORE_DEPTH_DEFAULT = 64;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAIL,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/core/crlfx_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
module crlfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/crlf_line_extractor_core.sv -----
// Top level: CR LF line framer over a ring store held in a RAM.
//
//  channel   | direction | tdata            | tuser                       | tlast
//  s_axis    | in        | [7:0] rx_byte    | -                           | -
//  m_axis    | out       | [7:0] line_byte  | [0] line_kind [1] dropped   | line_last
//
// s_axis_tready is low while a line is emitted.
// A finished non-empty line has its first and last byte read through the RAM read port,
// then is emitted one byte per cycle unless stalled, the single read port setting that pace.
// m_axis_tready low with a valid output holds the output register and stalls emission and input alike.
// Reset clears state, pointers, counts, the CR flag and output valid; the RAM contents are not cleared.
module crlf_line_extractor_core #(
    parameter int STORE_DEPTH = crlfx_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] line_byte
    output logic [1:0] m_axis_tuser,   // [0] line_kind, [1] byte_dropped
    output logic       m_axis_tlast
);

    import crlfx_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    state_t         state_reg, state_next;
    logic [AW-1:0]  line_start_reg, line_start_next;
    logic [AW-1:0]  wr_idx_reg, wr_idx_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           prev_cr_reg, prev_cr_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [CW-1:0]  len_reg, len_next;
    logic [CW-1:0]  remain_reg, remain_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic           open_reg, open_next;
    logic           kind_reg, kind_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_kind_reg, out_kind_next;
    logic           out_last_reg, out_last_next;
    logic           out_drop_reg, out_drop_next;

    logic           ram_wr_en;
    logic [7:0]     ram_rd_data;
    logic           out_free;
    logic           in_accept;
    logic [CW-1:0]  fill_inc;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(STORE_DEPTH))
        begin
            s = s - (AW+1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    crlfx_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (s_axis_tdata),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign fill_inc  = fill_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_start_reg <= '0;
            wr_idx_reg     <= '0;
            fill_reg       <= '0;
            prev_cr_reg    <= 1'b0;
            rd_ptr_reg     <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_start_reg <= line_start_next;
            wr_idx_reg     <= wr_idx_next;
            fill_reg       <= fill_next;
            prev_cr_reg    <= prev_cr_next;
            rd_ptr_reg     <= rd_ptr_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        len_reg      <= len_next;
        open_reg     <= open_next;
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        line_start_next = line_start_reg;
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        prev_cr_next    = prev_cr_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        rd_ptr_next     = rd_ptr_reg;
        open_next       = open_reg;
        kind_next       = kind_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_drop_next   = out_drop_reg;
        s_axis_tready   = 1'b0;
        ram_wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = out_free;
                if (in_accept)
                begin
                    if (fill_reg >= CW'(STORE_DEPTH))
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'h00;
                        out_kind_next  = 1'b0;
                        out_last_next  = 1'b0;
                        out_drop_next  = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        wr_idx_next = wrap_add(wr_idx_reg, AW'(1));
                        if (s_axis_tdata == CH_LF && prev_cr_reg && fill_inc >= CW'(2))
                        begin
                            line_start_next = wrap_add(wr_idx_reg, AW'(1));
                            fill_next       = '0;
                            prev_cr_next    = 1'b0;
                            base_next       = line_start_reg;
                            len_next        = fill_reg - CW'(1);
                            rd_ptr_next     = line_start_reg;
                            if (fill_reg != CW'(1))
                            begin
                                state_next = ST_HEAD;
                            end
                        end
                        else
                        begin
                            fill_next    = fill_inc;
                            prev_cr_next = (s_axis_tdata == CH_CR);
                        end
                    end
                end
            end

            ST_HEAD:
            begin
                open_next   = (ram_rd_data == CH_OPEN);
                rd_ptr_next = wrap_add(base_reg, AW'(len_reg - CW'(1)));
                state_next  = ST_TAIL;
            end

            ST_TAIL:
            begin
                if (len_reg > CW'(2) && open_reg && ram_rd_data == CH_CLOSE)
                begin
                    rd_ptr_next = wrap_add(base_reg, AW'(1));
                    remain_next = len_reg - CW'(2);
                    kind_next   = 1'b1;
                end
                else
                begin
                    rd_ptr_next = base_reg;
                    remain_next = len_reg;
                    kind_next   = 1'b0;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rd_data;
                    out_kind_next  = kind_reg;
                    out_last_next  = (remain_reg == CW'(1));
                    out_drop_next  = 1'b0;
                    remain_next    = remain_reg - CW'(1);
                    rd_ptr_next    = wrap_add(rd_ptr_reg, AW'(1));
                    if (remain_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_drop_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(STORE_DEPTH))
        else $error("fill count above store depth");

    a_emit_remain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> remain_reg != '0)
        else $error("emitting with nothing left");

    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("input ready while a line is in flight");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'h00 && !m_axis_tlast)
        else $error("drop transaction carries line data");

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HEAD |-> fill_reg == '0 && !prev_cr_reg)
        else $error("store not released at line end");
`endif

endmodule
